// File: rtl/irms_pkg.sv
// irms_pkg: shared types, codes and helper functions of the IPv4 rule match
// and steer block. No dependencies.
`default_nettype none
package irms_pkg;

  localparam logic [1:0] ACT_CLASSIFY = 2'd0;
  localparam logic [1:0] ACT_WRITE    = 2'd1;
  localparam logic [1:0] ACT_READ     = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] DSCP_ANY  = 8'hFF;

  typedef enum logic [2:0] {
    CMD_CLASSIFY,
    CMD_PASS,
    CMD_WRITE,
    CMD_READ,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [5:0]  slot;
    logic [1:0]  word_index;
    logic [63:0] word_value;
    logic [31:0] ingress_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  dscp;
    logic [7:0]  protocol;
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
  } cmd_t;

  typedef struct packed {
    logic        steered;
    logic [31:0] egress_port;
    logic [31:0] new_dst_addr;
    logic [15:0] new_ip_checksum;
    logic [15:0] new_l4_checksum;
    logic [47:0] new_dst_mac;
    logic [15:0] rule_id;
    logic [63:0] hit_count;
  } res_t;

  function automatic logic [31:0] pfx_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else if (len >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

  // RFC 1624: HC' = ~(~HC + ~m + m') over the two halves of the address
  function automatic logic [15:0] csum_upd(input logic [15:0] hc, input logic [31:0] oldv,
                                           input logic [31:0] newv);
    logic [18:0] s;
    logic [16:0] f;
    s = {3'b000, ~hc} + {3'b000, ~oldv[31:16]} + {3'b000, ~oldv[15:0]}
        + 19'(newv[31:16]) + 19'(newv[15:0]);
    f = 17'(s[15:0]) + 17'(s[18:16]);
    f = 17'(f[15:0]) + 17'(f[16]);
    return ~f[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/ipv4_rule_match_steer.sv
// ipv4_rule_match_steer: top level; front queue plus back-end sequencer.
// Depends on irms_pkg, irms_front, irms_back (and irms_ram through it).
//
// First-match IPv4 classifier with destination rewrite and incremental
// checksum update. After reset the block zeroes the rule and counter
// memories and holds in_stall_o high meanwhile. Rule writes, unused actions
// and unclassified headers are answered straight from the idle state; counter
// reads pass through a read state first. A classify transaction scans the
// rules in slot order, each rule taking a registered memory read and then a
// compare, and ends at a match, the first invalid slot or the last slot. On a
// match it builds the result, then bumps the hit counter if the rule id is in
// range. The scan loop over the rule memory sets the rate. A two-entry queue
// lets new transactions be taken while the sequencer works or a result waits.
`default_nettype none
module ipv4_rule_match_steer #(
  parameter int RULE_SLOTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [5:0]  slot_i,
  input  wire logic [1:0]  word_index_i,
  input  wire logic [63:0] word_value_i,
  input  wire logic [31:0] ingress_port_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic [5:0]  dscp_i,
  input  wire logic [7:0]  protocol_i,
  input  wire logic        eligible_i,
  input  wire logic [15:0] ip_checksum_i,
  input  wire logic [15:0] l4_checksum_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             steered_o,
  output logic [31:0]      egress_port_o,
  output logic [31:0]      new_dst_addr_o,
  output logic [15:0]      new_ip_checksum_o,
  output logic [15:0]      new_l4_checksum_o,
  output logic [47:0]      new_dst_mac_o,
  output logic [15:0]      rule_id_o,
  output logic [63:0]      hit_count_o
);
  import irms_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_pop, clearing;

  irms_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .slot_i        (slot_i),
    .word_index_i  (word_index_i),
    .word_value_i  (word_value_i),
    .ingress_port_i(ingress_port_i),
    .src_addr_i    (src_addr_i),
    .dst_addr_i    (dst_addr_i),
    .dscp_i        (dscp_i),
    .protocol_i    (protocol_i),
    .eligible_i    (eligible_i),
    .ip_checksum_i (ip_checksum_i),
    .l4_checksum_i (l4_checksum_i),
    .clearing_i    (clearing),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  irms_back #(.RULE_SLOTS(RULE_SLOTS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .clearing_o (clearing),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign steered_o         = res.steered;
  assign egress_port_o     = res.egress_port;
  assign new_dst_addr_o    = res.new_dst_addr;
  assign new_ip_checksum_o = res.new_ip_checksum;
  assign new_l4_checksum_o = res.new_l4_checksum;
  assign new_dst_mac_o     = res.new_dst_mac;
  assign rule_id_o         = res.rule_id;
  assign hit_count_o       = res.hit_count;

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (in_stall_o && !out_valid_o && !cmd_pop))
    else $error("transaction moved during memory clear");

  a_pass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !steered_o) |-> (egress_port_o == 32'd0 && rule_id_o == 16'd0
                                     && new_dst_mac_o == 48'd0))
    else $error("unsteered result carries rewrite fields");

  a_hit_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && steered_o) |-> (hit_count_o == 64'd0))
    else $error("steered result carries a counter value");

endmodule
`default_nettype wire

// File: rtl/irms_ram.sv
// irms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module irms_ram #(
  parameter int W = 64,
  parameter int D = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/irms_front.sv
// irms_front: accepts input transactions, sorts them by kind and holds them
// in a two-entry queue for the back end. Depends on irms_pkg.
`default_nettype none
module irms_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       action_i,
  input  wire logic [5:0]       slot_i,
  input  wire logic [1:0]       word_index_i,
  input  wire logic [63:0]      word_value_i,
  input  wire logic [31:0]      ingress_port_i,
  input  wire logic [31:0]      src_addr_i,
  input  wire logic [31:0]      dst_addr_i,
  input  wire logic [5:0]       dscp_i,
  input  wire logic [7:0]       protocol_i,
  input  wire logic             eligible_i,
  input  wire logic [15:0]      ip_checksum_i,
  input  wire logic [15:0]      l4_checksum_i,
  input  wire logic             clearing_i,
  output logic                  cmd_valid_o,
  output irms_pkg::cmd_t        cmd_o,
  input  wire logic             cmd_pop_i
);
  import irms_pkg::*;

  cmd_t       q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in              = '0;
    cmd_in.slot         = slot_i;
    cmd_in.word_index   = word_index_i;
    cmd_in.word_value   = word_value_i;
    cmd_in.ingress_port = ingress_port_i;
    cmd_in.src_addr     = src_addr_i;
    cmd_in.dst_addr     = dst_addr_i;
    cmd_in.dscp         = dscp_i;
    cmd_in.protocol     = protocol_i;
    cmd_in.ip_checksum  = ip_checksum_i;
    cmd_in.l4_checksum  = l4_checksum_i;
    case (action_i)
      ACT_CLASSIFY: cmd_in.kind = eligible_i ? CMD_CLASSIFY : CMD_PASS;
      ACT_WRITE:    cmd_in.kind = CMD_WRITE;
      ACT_READ:     cmd_in.kind = CMD_READ;
      default:      cmd_in.kind = CMD_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2) || clearing_i;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule
`default_nettype wire

// File: rtl/irms_back.sv
// irms_back: sequencer that runs queued transactions against the rule and
// counter memories and fills the output register. Depends on irms_pkg, irms_ram.
`default_nettype none
module irms_back #(
  parameter int RULE_SLOTS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  irms_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output irms_pkg::res_t      res_o
);
  import irms_pkg::*;

  localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_HIT   = 3'd4;
  localparam logic [2:0] S_CNTUP = 3'd5;
  localparam logic [2:0] S_RDCNT = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  cmd_t          cmd_q, cmd_d;
  logic [63:0]   w2_q, w2_d, w3_q, w3_d;
  logic          out_vld_q, out_vld_d;
  res_t          res_q, res_d;

  logic [3:0]    rule_we;
  logic [AW-1:0] rule_waddr;
  logic [63:0]   rule_wdata;
  logic [63:0]   rule_rd [4];
  logic          cnt_we;
  logic [AW-1:0] cnt_waddr, cnt_raddr;
  logic [63:0]   cnt_wdata, cnt_rd;

  logic          out_free, slot_ok, id_ok, last_rule, match;
  logic [15:0]   hit_id, l4_new;
  logic [31:0]   r_port, r_dst, r_src;
  logic [7:0]    r_dscp, r_proto;
  res_t          pass_res;

  for (genvar k = 0; k < 4; k++) begin : g_rule
    irms_ram #(.W(64), .D(RULE_SLOTS), .AW(AW)) u_rule (
      .clk_i  (clk_i),
      .we_i   (rule_we[k]),
      .waddr_i(rule_waddr),
      .wdata_i(rule_wdata),
      .raddr_i(idx_q),
      .rdata_o(rule_rd[k])
    );
  end

  irms_ram #(.W(64), .D(RULE_SLOTS), .AW(AW)) u_cnt (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rd)
  );

  assign out_free  = !out_vld_q || !out_stall_i;
  assign slot_ok   = (11'(cmd_i.slot) < 11'(RULE_SLOTS));
  assign hit_id    = w3_q[63:48];
  assign id_ok     = (hit_id < 16'(RULE_SLOTS));
  assign last_rule = ((AW + 1)'(idx_q) + 1'b1) == (AW + 1)'(RULE_SLOTS);

  assign r_port  = rule_rd[0][63:32];
  assign r_dscp  = rule_rd[0][15:8];
  assign r_proto = rule_rd[0][23:16];
  assign r_dst   = rule_rd[1][31:0];
  assign r_src   = rule_rd[1][63:32];

  assign match = (r_port == 32'd0 || r_port == cmd_q.ingress_port)
              && (r_dst == 32'd0
                  || ((cmd_q.dst_addr ^ r_dst) & pfx_mask(rule_rd[0][29:24])) == 32'd0)
              && (r_src == 32'd0
                  || ((cmd_q.src_addr ^ r_src) & pfx_mask(rule_rd[0][7:2])) == 32'd0)
              && (r_dscp == DSCP_ANY || r_dscp == 8'(cmd_q.dscp))
              && (r_proto == 8'd0 || r_proto == cmd_q.protocol);

  always_comb begin
    pass_res                 = '0;
    pass_res.new_dst_addr    = cmd_q.dst_addr;
    pass_res.new_ip_checksum = cmd_q.ip_checksum;
    pass_res.new_l4_checksum = cmd_q.l4_checksum;
  end

  // TCP always, UDP only with a checksum in use; zero goes out as all ones
  always_comb begin
    l4_new = cmd_q.l4_checksum;
    if (cmd_q.protocol == PROTO_TCP) begin
      l4_new = csum_upd(cmd_q.l4_checksum, cmd_q.dst_addr, w2_q[31:0]);
    end else if (cmd_q.protocol == PROTO_UDP && cmd_q.l4_checksum != 16'd0) begin
      l4_new = csum_upd(cmd_q.l4_checksum, cmd_q.dst_addr, w2_q[31:0]);
      if (l4_new == 16'd0) begin
        l4_new = 16'hFFFF;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    w2_d       = w2_q;
    w3_d       = w3_q;
    out_vld_d  = out_vld_q && out_stall_i;
    res_d      = res_q;
    cmd_pop_o  = 1'b0;
    rule_we    = 4'd0;
    rule_waddr = AW'(cmd_i.slot);
    rule_wdata = cmd_i.word_value;
    cnt_we     = 1'b0;
    cnt_waddr  = AW'(hit_id);
    cnt_wdata  = cnt_rd + 64'd1;
    cnt_raddr  = AW'(cmd_i.slot);
    case (state_q)
      S_CLEAR: begin
        rule_we    = 4'hF;
        rule_waddr = idx_q;
        rule_wdata = 64'd0;
        cnt_we     = 1'b1;
        cnt_waddr  = idx_q;
        cnt_wdata  = 64'd0;
        idx_d      = idx_q + 1'b1;
        if (last_rule) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.kind)
            CMD_CLASSIFY: begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
            CMD_PASS: begin
              out_vld_d             = 1'b1;
              res_d                 = '0;
              res_d.new_dst_addr    = cmd_i.dst_addr;
              res_d.new_ip_checksum = cmd_i.ip_checksum;
              res_d.new_l4_checksum = cmd_i.l4_checksum;
            end
            CMD_WRITE: begin
              rule_we[cmd_i.word_index] = slot_ok;
              out_vld_d = 1'b1;
              res_d     = '0;
            end
            CMD_READ: begin
              if (slot_ok) begin
                state_d = S_RDCNT;
              end else begin
                out_vld_d = 1'b1;
                res_d     = '0;
              end
            end
            default: begin
              out_vld_d = 1'b1;
              res_d     = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!rule_rd[0][0]) begin
          out_vld_d = 1'b1;
          res_d     = pass_res;
          state_d   = S_IDLE;
        end else if (match) begin
          w2_d    = rule_rd[2];
          w3_d    = rule_rd[3];
          state_d = S_HIT;
        end else if (last_rule) begin
          out_vld_d = 1'b1;
          res_d     = pass_res;
          state_d   = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_HIT: begin
        out_vld_d             = 1'b1;
        res_d                 = '0;
        res_d.steered         = 1'b1;
        res_d.egress_port     = w2_q[63:32];
        res_d.new_dst_addr    = w2_q[31:0];
        res_d.new_ip_checksum = csum_upd(cmd_q.ip_checksum, cmd_q.dst_addr, w2_q[31:0]);
        res_d.new_l4_checksum = l4_new;
        res_d.new_dst_mac     = w3_q[47:0];
        res_d.rule_id         = hit_id;
        cnt_raddr             = AW'(hit_id);
        state_d               = id_ok ? S_CNTUP : S_IDLE;
      end
      S_CNTUP: begin
        cnt_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_RDCNT: begin
        out_vld_d       = 1'b1;
        res_d           = '0;
        res_d.hit_count = cnt_rd;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    w2_q  <= w2_d;
    w3_q  <= w3_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire
